>>> rtl/kbst_pkg.sv
// Shared types, codes and constants for the keyed beam slot table.
package kbst_pkg;

    localparam int KEY_W   = 16;
    localparam int KIND_W  = 3;
    localparam int TIME_W  = 32;
    localparam int LIFE_W  = 16;
    localparam int VIEW_W  = 15;
    localparam int COORD_W = 16;
    localparam int VEC_W   = 3 * COORD_W;
    localparam int SLOT_W  = 5;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [LIFE_W-1:0] LIFETIME_RST = 16'd200;
    localparam logic [VIEW_W-1:0] VIEW_RST     = 15'd1;

    localparam logic signed [KEY_W-1:0] TRAIL_KEY_MIN = -16'sd512;
    localparam logic [7:0]              KIND_RAIL     = 8'd1;
    localparam logic [KIND_W-1:0]       KIND_EMPTY    = 3'd0;
    localparam logic [KIND_W-1:0]       KIND_OTHER    = 3'd4;

    // register select is paddr[2]
    localparam logic REG_LIFETIME = 1'b0;
    localparam logic REG_VIEW     = 1'b1;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_ALLOCATED = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_TRAIL     = 3'd3,
        ST_SKIPPED   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [KEY_W-1:0]   entity_key;
        logic [7:0]                beam_kind;
        logic [TIME_W-1:0]         now;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
        logic                      seeking;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot_index;
        logic [7:0]        trail_colour;
        logic [5:0]        trail_player;
        logic              own_beam;
    } t_result;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] expiry;
    } t_slot;

    typedef struct packed {
        logic load;
        logic scan;
        logic write;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic normal;
        logic scan_done;
        logic out_free;
    } t_stat;

    function automatic logic [7:0] trail_colour(input logic [2:0] sel);
        logic [7:0] c;
        case (sel)
            3'd0:    c = 8'd6;
            3'd1:    c = 8'd208;
            3'd2:    c = 8'd180;
            3'd3:    c = 8'd35;
            3'd4:    c = 8'd224;
            3'd5:    c = 8'd133;
            3'd6:    c = 8'd192;
            default: c = 8'd6;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/kbst_if.sv
// Request and result channel interfaces of the keyed beam slot table.
interface kbst_req_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  entity_key;
    logic [7:0]          beam_kind;
    logic [31:0]         now;
    logic signed [15:0]  start_x;
    logic signed [15:0]  start_y;
    logic signed [15:0]  start_z;
    logic signed [15:0]  end_x;
    logic signed [15:0]  end_y;
    logic signed [15:0]  end_z;
    logic                seeking;

    modport source (
        output valid, entity_key, beam_kind, now, start_x, start_y, start_z,
               end_x, end_y, end_z, seeking,
        input  ready
    );
    modport sink (
        input  valid, entity_key, beam_kind, now, start_x, start_y, start_z,
               end_x, end_y, end_z, seeking,
        output ready
    );
endinterface

interface kbst_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  slot_index;
    logic [7:0]  trail_colour;
    logic [5:0]  trail_player;
    logic        own_beam;

    modport source (
        output valid, status, slot_index, trail_colour, trail_player, own_beam,
        input  ready
    );
    modport sink (
        input  valid, status, slot_index, trail_colour, trail_player, own_beam,
        output ready
    );
endinterface

>>> rtl/kbst_ctrl.sv
// Sequencer for one request: accept, slot scan and slot write (normal requests only), result hand-off.
module kbst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  kbst_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output kbst_pkg::t_cmd  o_cmd
);

    kbst_pkg::t_state r_state;
    kbst_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kbst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            kbst_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = kbst_pkg::S_SCAN;
                end
            end
            kbst_pkg::S_SCAN: begin
                if (!i_stat.normal) begin
                    n_state = kbst_pkg::S_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_stat.scan_done) begin
                        n_state = kbst_pkg::S_WRITE;
                    end
                end
            end
            kbst_pkg::S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = kbst_pkg::S_DONE;
            end
            kbst_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = kbst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kbst_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/kbst_dp.sv
// Datapath: request registers, slot memory, scan unit and result register.
module kbst_dp #(
    parameter int NUM_SLOTS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kbst_pkg::t_cmd                  i_cmd,
    input  kbst_pkg::t_req                  i_req,
    input  logic [kbst_pkg::LIFE_W-1:0]     i_lifetime,
    input  logic [kbst_pkg::VIEW_W-1:0]     i_view,
    input  logic                            i_out_ready,
    output kbst_pkg::t_stat                 o_stat,
    output logic                            o_out_valid,
    output kbst_pkg::t_result               o_out
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam logic [IW:0] SLOTS_END = (IW+1)'(NUM_SLOTS);

    // slot memory: key/kind/expiry, plus coordinates
    kbst_pkg::t_slot                       r_mem [NUM_SLOTS];
    logic [2*kbst_pkg::VEC_W-1:0]          r_vec_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]                  r_valid;

    logic [kbst_pkg::KEY_W-1:0]            r_key;
    logic [kbst_pkg::KIND_W-1:0]           r_kind;
    logic [kbst_pkg::TIME_W-1:0]           r_now;
    logic [kbst_pkg::TIME_W-1:0]           r_expiry;
    logic [kbst_pkg::VEC_W-1:0]            r_start;
    logic [kbst_pkg::VEC_W-1:0]            r_end;
    logic [kbst_pkg::VEC_W-1:0]            r_own_end;
    logic                                  r_skip;
    logic                                  r_trail;
    logic                                  r_own;

    logic [IW:0]                           r_iss_cnt;
    logic                                  r_rd_vld;
    logic [IW-1:0]                         r_rd_idx;
    kbst_pkg::t_slot                       r_rd_word;
    logic                                  r_rd_vb;
    logic                                  r_match_hit;
    logic [IW-1:0]                         r_match_idx;
    logic                                  r_free_hit;
    logic [IW-1:0]                         r_free_idx;

    logic                                  r_out_valid;
    kbst_pkg::t_result                     r_out;

    logic                                  req_trail;
    logic                                  req_normal;
    logic [kbst_pkg::KIND_W-1:0]           req_kind;
    logic [kbst_pkg::TIME_W:0]             exp_sum;
    logic [kbst_pkg::TIME_W-1:0]           req_expiry;
    logic                                  req_own;
    logic                                  issue;
    logic [IW-1:0]                         rd_addr;
    kbst_pkg::t_slot                       cur;
    logic                                  eval;
    logic                                  cur_match;
    logic                                  cur_free;
    logic                                  hit;
    logic [IW-1:0]                         wr_addr;
    kbst_pkg::t_result                     res;

    always_comb begin
        req_trail = (i_req.beam_kind == kbst_pkg::KIND_RAIL)
                 && (i_req.entity_key >= kbst_pkg::TRAIL_KEY_MIN)
                 && i_req.entity_key[kbst_pkg::KEY_W-1];
        req_normal = !i_req.seeking && !req_trail;
        if (i_req.beam_kind inside {[8'd1:8'd3]}) begin
            req_kind = i_req.beam_kind[kbst_pkg::KIND_W-1:0];
        end else begin
            req_kind = kbst_pkg::KIND_OTHER;
        end
        exp_sum    = {1'b0, i_req.now} + (kbst_pkg::TIME_W+1)'(i_lifetime);
        req_expiry = exp_sum[kbst_pkg::TIME_W] ? '1 : exp_sum[kbst_pkg::TIME_W-1:0];
        req_own    = req_normal && (i_req.entity_key == {1'b0, i_view});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= i_req.entity_key;
            r_kind   <= req_kind;
            r_now    <= i_req.now;
            r_expiry <= req_expiry;
            r_start  <= {i_req.start_z, i_req.start_y, i_req.start_x};
            r_end    <= {i_req.end_z, i_req.end_y, i_req.end_x};
        end
        if (i_cmd.load && req_own) begin
            r_own_end <= {i_req.end_z, i_req.end_y, i_req.end_x};
        end
    end

    // scan: one slot read per cycle, result evaluated in the cycle after the read
    assign issue   = i_cmd.scan && (r_iss_cnt < SLOTS_END) && !r_match_hit;
    assign rd_addr = r_iss_cnt[IW-1:0];
    assign cur     = r_rd_vb ? r_rd_word : '0;
    assign eval    = i_cmd.scan && r_rd_vld;
    assign cur_match = (cur.key == r_key);
    assign cur_free  = (cur.kind == kbst_pkg::KIND_EMPTY) || (cur.expiry < r_now);
    assign hit     = r_match_hit || r_free_hit;
    assign wr_addr = r_match_hit ? r_match_idx : r_free_idx;

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_word <= r_mem[rd_addr];
            r_rd_vb   <= r_valid[rd_addr];
            r_rd_idx  <= rd_addr;
        end
        if (eval && cur_match && !r_match_hit) begin
            r_match_idx <= r_rd_idx;
        end
        if (eval && cur_free && !r_free_hit) begin
            r_free_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && r_match_hit == 1'b0 && r_free_hit == 1'b0) begin
        end else if (i_cmd.write) begin
            r_mem[wr_addr]     <= '{key: r_key, kind: r_kind, expiry: r_expiry};
            r_vec_mem[wr_addr] <= {r_end, r_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_skip      <= 1'b0;
            r_trail     <= 1'b0;
            r_own       <= 1'b0;
            r_iss_cnt   <= '0;
            r_rd_vld    <= 1'b0;
            r_match_hit <= 1'b0;
            r_free_hit  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_skip      <= i_req.seeking;
                r_trail     <= !i_req.seeking && req_trail;
                r_own       <= req_own;
                r_iss_cnt   <= '0;
                r_rd_vld    <= 1'b0;
                r_match_hit <= 1'b0;
                r_free_hit  <= 1'b0;
            end else begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_iss_cnt <= r_iss_cnt + (IW+1)'(1);
                end
                if (eval && cur_match) begin
                    r_match_hit <= 1'b1;
                end
                if (eval && cur_free) begin
                    r_free_hit <= 1'b1;
                end
            end
            if (i_cmd.write && hit) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        res = '0;
        if (r_skip) begin
            res.status = kbst_pkg::ST_SKIPPED;
        end else if (r_trail) begin
            res.status       = kbst_pkg::ST_TRAIL;
            res.trail_colour = kbst_pkg::trail_colour(r_key[2:0]);
            res.trail_player = r_key[8:3];
        end else begin
            res.own_beam = r_own;
            if (r_match_hit) begin
                res.status     = kbst_pkg::ST_UPDATED;
                res.slot_index = kbst_pkg::SLOT_W'(r_match_idx);
            end else if (r_free_hit) begin
                res.status     = kbst_pkg::ST_ALLOCATED;
                res.slot_index = kbst_pkg::SLOT_W'(r_free_idx);
            end else begin
                res.status = kbst_pkg::ST_OVERFLOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= res;
        end
    end

    assign o_stat.normal    = !r_skip && !r_trail;
    assign o_stat.scan_done = r_match_hit || ((r_iss_cnt == SLOTS_END) && !r_rd_vld);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out            = r_out;

endmodule

>>> rtl/keyed_beam_slot_table.sv
// Keyed beam slot table: top level with configuration registers and channels.
// One beat in gives one beat out. A skipped request or a rail trail skips
// the slot scan and write and goes straight to its result. Any other
// request scans the slot memory through its single read port, one slot per
// cycle, and a key match ends the scan early. A new request is accepted
// once the previous result has moved into the output register. After reset
// every slot reads as empty with key zero; no clearing pass is needed.
module keyed_beam_slot_table #(
    parameter int NUM_SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    kbst_req_if.sink                      i_req,
    kbst_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kbst_pkg::ADDR_W-1:0]   paddr,
    input  logic [kbst_pkg::DATA_W-1:0]   pwdata,
    output logic [kbst_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [kbst_pkg::LIFE_W-1:0] r_lifetime;
    logic [kbst_pkg::VIEW_W-1:0] r_view;

    logic                        cfg_wr;
    logic                        in_ready;
    logic                        out_valid;
    kbst_pkg::t_cmd              cmd;
    kbst_pkg::t_stat             stat;
    kbst_pkg::t_req              req;
    kbst_pkg::t_result           out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= kbst_pkg::LIFETIME_RST;
            r_view     <= kbst_pkg::VIEW_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                kbst_pkg::REG_LIFETIME: r_lifetime <= pwdata[kbst_pkg::LIFE_W-1:0];
                kbst_pkg::REG_VIEW:     r_view     <= pwdata[kbst_pkg::VIEW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            kbst_pkg::REG_LIFETIME: prdata = kbst_pkg::DATA_W'(r_lifetime);
            kbst_pkg::REG_VIEW:     prdata = kbst_pkg::DATA_W'(r_view);
            default:                prdata = '0;
        endcase
    end

    assign req.entity_key = i_req.entity_key;
    assign req.beam_kind  = i_req.beam_kind;
    assign req.now        = i_req.now;
    assign req.start_x    = i_req.start_x;
    assign req.start_y    = i_req.start_y;
    assign req.start_z    = i_req.start_z;
    assign req.end_x      = i_req.end_x;
    assign req.end_y      = i_req.end_y;
    assign req.end_z      = i_req.end_z;
    assign req.seeking    = i_req.seeking;

    kbst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    kbst_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (req),
        .i_lifetime  (r_lifetime),
        .i_view      (r_view),
        .i_out_ready (o_rsp.ready),
        .o_stat      (stat),
        .o_out_valid (out_valid),
        .o_out       (out)
    );

    assign i_req.ready        = in_ready;
    assign o_rsp.valid        = out_valid;
    assign o_rsp.status       = out.status;
    assign o_rsp.slot_index   = out.slot_index;
    assign o_rsp.trail_colour = out.trail_colour;
    assign o_rsp.trail_player = out.trail_player;
    assign o_rsp.own_beam     = out.own_beam;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in progress");

    a_own_only_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.own_beam) |->
            (out.status == kbst_pkg::ST_UPDATED || out.status == kbst_pkg::ST_ALLOCATED
             || out.status == kbst_pkg::ST_OVERFLOW))
        else $error("own beam flagged on a trail or skipped beat");

    a_slot_only_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && out.status != kbst_pkg::ST_UPDATED
         && out.status != kbst_pkg::ST_ALLOCATED) |-> (o_rsp.slot_index == '0))
        else $error("slot index set without a slot write");

    a_trail_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && out.status != kbst_pkg::ST_TRAIL) |->
            (o_rsp.trail_colour == '0 && o_rsp.trail_player == '0))
        else $error("trail fields set on a non-trail beat");

endmodule

>>> test/keyed_beam_slot_table_checker.sv
// Checker for the keyed beam slot table: watches both channels and the APB port, predicts results.
`timescale 1ns / 1ps

module keyed_beam_slot_table_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    kbst_req_if                         i_req,
    kbst_rsp_if                         i_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [kbst_pkg::ADDR_W-1:0] paddr,
    input  logic [kbst_pkg::DATA_W-1:0] pwdata,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    localparam int SLOTS = 32;
    localparam logic [7:0] TRAIL_PALETTE [8] = '{8'd6, 8'd208, 8'd180, 8'd35,
                                                 8'd224, 8'd133, 8'd192, 8'd6};

    logic [kbst_pkg::LIFE_W-1:0] life_ms;
    logic [kbst_pkg::VIEW_W-1:0] view_key;

    logic [kbst_pkg::KEY_W-1:0]  tbl_key    [SLOTS];
    logic [kbst_pkg::KIND_W-1:0] tbl_kind   [SLOTS];
    logic [kbst_pkg::TIME_W-1:0] tbl_expiry [SLOTS];
    logic [kbst_pkg::VEC_W-1:0]  tbl_start  [SLOTS];
    logic [kbst_pkg::VEC_W-1:0]  tbl_end    [SLOTS];

    kbst_pkg::t_result beam_outcomes [$];
    int                fails;
    int                checked;

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (fails < 50)
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        fails++;
    endtask

    // Updates the slot table for one request beat and returns its result.
    function automatic kbst_pkg::t_result beam_outcome(input kbst_pkg::t_req r);
        kbst_pkg::t_result           res;
        logic [kbst_pkg::KEY_W-1:0]  key;
        logic [kbst_pkg::KIND_W-1:0] kind;
        logic [kbst_pkg::TIME_W:0]   sum;
        logic [kbst_pkg::TIME_W-1:0] expiry;
        int                          hit;
        res = '0;
        key = r.entity_key;
        hit = -1;
        if (r.seeking) begin
            res.status = kbst_pkg::ST_SKIPPED;
        end else if (r.beam_kind == kbst_pkg::KIND_RAIL && $signed(r.entity_key) < 16'sd0 &&
                     $signed(r.entity_key) >= kbst_pkg::TRAIL_KEY_MIN) begin
            res.status       = kbst_pkg::ST_TRAIL;
            res.trail_colour = TRAIL_PALETTE[key[2:0]];
            res.trail_player = key[8:3];
        end else begin
            kind = (r.beam_kind >= 8'd1 && r.beam_kind <= 8'd3) ? r.beam_kind[2:0]
                                                                 : kbst_pkg::KIND_OTHER;
            sum = {1'b0, r.now} + {17'b0, life_ms};
            expiry = sum[kbst_pkg::TIME_W] ? '1 : sum[kbst_pkg::TIME_W-1:0];
            if (key == {1'b0, view_key})
                res.own_beam = 1'b1;
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && tbl_key[i] == key)
                    hit = i;
            if (hit >= 0) begin
                res.status = kbst_pkg::ST_UPDATED;
            end else begin
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && (tbl_kind[i] == kbst_pkg::KIND_EMPTY
                                    || tbl_expiry[i] < r.now))
                        hit = i;
                res.status = (hit >= 0) ? kbst_pkg::ST_ALLOCATED : kbst_pkg::ST_OVERFLOW;
            end
            if (hit >= 0) begin
                tbl_key[hit]    = key;
                tbl_kind[hit]   = kind;
                tbl_expiry[hit] = expiry;
                tbl_start[hit]  = {r.start_z, r.start_y, r.start_x};
                tbl_end[hit]    = {r.end_z, r.end_y, r.end_x};
                res.slot_index  = 5'(hit);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        kbst_pkg::t_req    beat;
        kbst_pkg::t_result want;
        if (!i_rst_n) begin
            life_ms  = kbst_pkg::LIFETIME_RST;
            view_key = kbst_pkg::VIEW_RST;
            for (int i = 0; i < SLOTS; i++) begin
                tbl_key[i]    = '0;
                tbl_kind[i]   = kbst_pkg::KIND_EMPTY;
                tbl_expiry[i] = '0;
                tbl_start[i]  = '0;
                tbl_end[i]    = '0;
            end
            beam_outcomes.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                checked++;
                if (beam_outcomes.size() == 0) begin
                    note_mismatch("result beat with no request", 32'(i_rsp.status), 0);
                end else begin
                    want = beam_outcomes.pop_front();
                    if (i_rsp.status !== want.status)
                        note_mismatch("status", 32'(i_rsp.status), 32'(want.status));
                    if (i_rsp.slot_index !== want.slot_index)
                        note_mismatch("slot_index", 32'(i_rsp.slot_index),
                                      32'(want.slot_index));
                    if (i_rsp.trail_colour !== want.trail_colour)
                        note_mismatch("trail_colour", 32'(i_rsp.trail_colour),
                                      32'(want.trail_colour));
                    if (i_rsp.trail_player !== want.trail_player)
                        note_mismatch("trail_player", 32'(i_rsp.trail_player),
                                      32'(want.trail_player));
                    if (i_rsp.own_beam !== want.own_beam)
                        note_mismatch("own_beam", 32'(i_rsp.own_beam), 32'(want.own_beam));
                end
            end
            if (i_req.valid && i_req.ready) begin
                beat.entity_key = i_req.entity_key;
                beat.beam_kind  = i_req.beam_kind;
                beat.now        = i_req.now;
                beat.start_x    = i_req.start_x;
                beat.start_y    = i_req.start_y;
                beat.start_z    = i_req.start_z;
                beat.end_x      = i_req.end_x;
                beat.end_y      = i_req.end_y;
                beat.end_z      = i_req.end_z;
                beat.seeking    = i_req.seeking;
                beam_outcomes.push_back(beam_outcome(beat));
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == kbst_pkg::REG_LIFETIME)
                    life_ms = pwdata[kbst_pkg::LIFE_W-1:0];
                else
                    view_key = pwdata[kbst_pkg::VIEW_W-1:0];
            end
        end
        o_pending    <= beam_outcomes.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

>>> test/keyed_beam_slot_table_test.sv
// Testbench top for the keyed beam slot table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module keyed_beam_slot_table_test;

    localparam int PHASES      = 9;
    localparam int PHASE_BEATS = 200;
    localparam int HOLD_CYCLES = 400;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [kbst_pkg::ADDR_W-1:0] paddr;
    logic [kbst_pkg::DATA_W-1:0] pwdata;
    logic [kbst_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    int fail_count;
    int pending;
    int checked;
    int beats_sent;

    bit no_idle;
    bit hold_go;

    // per phase: lifetime, view key (-1 random), key pool size, time step shift
    int unsigned phase_life  [PHASES] = '{1, 65535, 0, 1000, 37, 65535, 5000, 200, 300};
    int          phase_view  [PHASES] = '{0, 32767, -1, -1, 0, -1, 32767, -1, -1};
    int          phase_pool  [PHASES] = '{24, 48, 40, 6, 40, 48, 20, 36, 40};
    int          phase_shift [PHASES] = '{2, 8, 4, 5, 3, 6, 4, 5, 4};

    kbst_req_if req_ch ();
    kbst_rsp_if rsp_ch ();

    keyed_beam_slot_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    keyed_beam_slot_table_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= no_idle || ($urandom_range(99) >= 14);
            end
        end
    end

    function automatic kbst_pkg::t_req beam_req(input logic [15:0] key,
                                                input logic [7:0] kind,
                                                input logic [31:0] at, input logic seek);
        kbst_pkg::t_req r;
        r.entity_key = key;
        r.beam_kind  = kind;
        r.now        = at;
        r.start_x    = 16'($urandom);
        r.start_y    = 16'($urandom);
        r.start_z    = 16'($urandom);
        r.end_x      = 16'($urandom);
        r.end_y      = 16'($urandom);
        r.end_z      = 16'($urandom);
        r.seeking    = seek;
        return r;
    endfunction

    task automatic offer_beat(input kbst_pkg::t_req r);
        if (!no_idle && $urandom_range(99) < 14) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.entity_key <= r.entity_key;
        req_ch.beam_kind  <= r.beam_kind;
        req_ch.now        <= r.now;
        req_ch.start_x    <= r.start_x;
        req_ch.start_y    <= r.start_y;
        req_ch.start_z    <= r.start_z;
        req_ch.end_x      <= r.end_x;
        req_ch.end_y      <= r.end_y;
        req_ch.end_z      <= r.end_z;
        req_ch.seeking    <= r.seeking;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [kbst_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        kbst_pkg::t_req    r;
        logic [15:0]       key_pool [48];
        logic [14:0]       cur_view;
        logic [31:0]       t_cur;
        logic [31:0]       base;
        logic [32:0]       nxt;
        int unsigned       step_max;
        int                pool_n;
        int                pick;

        i_rst_n <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.entity_key <= '0;
        req_ch.beam_kind  <= '0;
        req_ch.now        <= '0;
        req_ch.start_x    <= '0;
        req_ch.start_y    <= '0;
        req_ch.start_z    <= '0;
        req_ch.end_x      <= '0;
        req_ch.end_y      <= '0;
        req_ch.end_z      <= '0;
        req_ch.seeking    <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: key 0 hits an empty slot, own beam, kinds, coordinate extremes
        offer_beat(beam_req(16'd0, 8'd2, 32'd1000, 1'b0));
        offer_beat(beam_req(16'd1, 8'd3, 32'd1000, 1'b0));
        offer_beat(beam_req(16'd1, 8'd0, 32'd1010, 1'b0));
        r = beam_req(16'd5, 8'd255, 32'd1020, 1'b0);
        r.start_x = 16'sh7FFF; r.start_y = 16'sh7FFF; r.start_z = 16'sh7FFF;
        r.end_x   = 16'sh7FFF; r.end_y   = 16'sh7FFF; r.end_z   = 16'sh7FFF;
        offer_beat(r);
        r = beam_req(16'd7, 8'd4, 32'd1020, 1'b0);
        r.start_x = 16'sh8000; r.start_y = 16'sh8000; r.start_z = 16'sh8000;
        r.end_x   = 16'sh8000; r.end_y   = 16'sh8000; r.end_z   = 16'sh8000;
        offer_beat(r);
        // rail trails over every palette entry, then the range edges
        for (int k = 0; k < 8; k++)
            offer_beat(beam_req(16'(k - 512), kbst_pkg::KIND_RAIL, 32'($urandom), 1'b0));
        offer_beat(beam_req(16'hFFFF, kbst_pkg::KIND_RAIL, 32'd1030, 1'b0));
        offer_beat(beam_req(16'hFDFF, kbst_pkg::KIND_RAIL, 32'd1030, 1'b0));
        offer_beat(beam_req(16'hFFFF, 8'd2, 32'd1030, 1'b0));
        offer_beat(beam_req(16'hFF38, kbst_pkg::KIND_RAIL, 32'd1040, 1'b1));
        offer_beat(beam_req(16'd1, 8'd1, 32'd1040, 1'b1));
        // expiry saturation, most negative key, expired slot reuse
        offer_beat(beam_req(16'h7FFF, 8'd3, 32'hFFFF_FFF0, 1'b0));
        offer_beat(beam_req(16'h8000, kbst_pkg::KIND_RAIL, 32'd0, 1'b0));
        offer_beat(beam_req(16'd9, 8'd2, 32'd5000, 1'b0));
        offer_beat(beam_req(16'd0, 8'd128, 32'd5000, 1'b0));
        drain();

        t_cur = 32'd6000;
        for (int ph = 0; ph < PHASES; ph++) begin
            cur_view = (phase_view[ph] < 0) ? 15'($urandom) : 15'(phase_view[ph]);
            write_reg(kbst_pkg::REG_LIFETIME, kbst_pkg::DATA_W'(phase_life[ph]));
            write_reg(kbst_pkg::REG_VIEW, kbst_pkg::DATA_W'(cur_view));
            pool_n   = phase_pool[ph];
            step_max = (phase_life[ph] >> phase_shift[ph]) + 1;
            key_pool[0] = {1'b0, cur_view};
            key_pool[1] = 16'd0;
            for (int k = 2; k < 48; k++)
                key_pool[k] = k[0] ? 16'($urandom) : 16'($urandom_range(0, 63));
            base = 32'(ph) * 32'h1C00_0000 + 32'($urandom_range(0, 1000));
            if (ph == PHASES - 1)
                base = 32'hFFFF_FC00;
            if (base > t_cur)
                t_cur = base;
            no_idle = (ph == 4);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if (ph == 2 && k == 60)
                    hold_go = 1'b1;
                pick = $urandom_range(99);
                r = beam_req(16'($urandom), 8'($urandom), $urandom, 1'b0);
                if (pick < 6) begin
                    r.seeking = 1'b1;
                end else if (pick < 14) begin
                    r.beam_kind  = kbst_pkg::KIND_RAIL;
                    r.entity_key = 16'(0 - $urandom_range(1, 512));
                end else if (pick < 18) begin
                    r.now = t_cur;
                end else begin
                    r.entity_key = key_pool[$urandom_range(pool_n - 1)];
                    if ($urandom_range(4) != 0)
                        r.beam_kind = 8'($urandom_range(1, 4));
                    r.now = t_cur;
                    nxt = {1'b0, t_cur} + 33'($urandom_range(0, step_max));
                    t_cur = nxt[32] ? '1 : nxt[31:0];
                end
                offer_beat(r);
            end
            drain();
        end
        no_idle = 1'b0;

        repeat (40) @(posedge i_clk);
        $display("Covered %0d request beats: directed edge cases, then %0d register settings",
                 beats_sent, PHASES);
        $display("with matches, allocation, expiry reuse, overflow and trails; %0d compared",
                 checked);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
